@@ src/pfa_pkg.sv @@
// Package with the shared types and codes of the paged frame allocator.
package pfa_pkg;

   // Table sizes.
   localparam int NUM_FRAMES = 64;
   localparam int MAX_PROCS  = 16;
   localparam int MAX_PAGES  = 32;

   // Request opcodes.
   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_MAP    = 2'd1;
   localparam logic [1:0] OP_FRAME  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Result status codes.
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_NO_FRAMES = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;
   localparam logic [2:0] ST_BAD_FRAME = 3'd6;

   // Configuration register indexes.
   localparam logic [1:0] REG_PAGE_BYTES  = 2'd0;
   localparam logic [1:0] REG_MAX_BYTES   = 2'd1;
   localparam logic [1:0] REG_FRAME_COUNT = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] proc_id;
      logic [15:0] size_bytes;
      logic [5:0]  frame_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  page_index;
      logic [5:0]  frame_number;
      logic [5:0]  page_total;
      logic        entry_valid;
      logic        frame_in_use;
      logic [15:0] owner_id;
      logic        last;
   } rsp_type;

   // Control from the sequencer to the page-count divider.
   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
      logic [12:0] divisor;
   } div_ctl_type;

endpackage

@@ src/pfa_divider.sv @@
// Bit-serial divider that yields the rounded-up page count of a size.
module pfa_divider
   import pfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   output logic        done,
   output logic [16:0] pages
);

   logic [16:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [12:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quo_ff[15]};
      if (ctl.start) begin
         rem_in = '0;
         quo_in = ctl.dividend;
         dvs_in = (ctl.divisor == 13'd0) ? 13'd1 : ctl.divisor;
         cnt_in = 5'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {4'd0, dvs_ff}) begin
            rem_in = trial - {4'd0, dvs_ff};
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign pages = {1'b0, quo_ff} + {16'd0, (rem_ff != 17'd0)};

endmodule

@@ src/paged_frame_allocator.sv @@
// Top level of the paged frame allocator: sequencer and table memories.
//
// A request transfer happens at a clock edge where start is high and busy is low; opcode 3
// is taken and gives no result. busy falls in the cycle that shows the last result, so the
// next request can be taken there. Results appear on rsp_data for one cycle each, flagged
// by rsp_valid; the final one has last set. The receiver cannot stall the block.
// A frame query reads the owner table and then shows its result. The id search makes a
// table read and then a compare for each stored process, and a final check when no entry
// matches. A page-map query then reads the page count, then a map read and a result for
// each page. A create takes the search, the bit-serial page-count divider, one frame
// popped per cycle and a closing step, then a map read and a result for each page.
// Configuration writes are taken on the csr_ channel only while idle with start low. A
// frame_count write rebuilds the pool; the frame-used bits are flip-flops cleared at once.
// Reset restores page_bytes 32, max_process_bytes 256, frame_count 32
// and an empty process table.
module paged_frame_allocator
   import pfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CW = $clog2(NUM_FRAMES + 1);
   localparam int TW = $clog2(MAX_PROCS + 1);
   localparam int NW = $clog2(MAX_PAGES + 1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SRCH   = 4'd1;
   localparam logic [3:0] S_SCMP   = 4'd2;
   localparam logic [3:0] S_DIV    = 4'd3;
   localparam logic [3:0] S_ALLOC  = 4'd4;
   localparam logic [3:0] S_LRD    = 4'd5;
   localparam logic [3:0] S_LOUT   = 4'd6;
   localparam logic [3:0] S_FRD    = 4'd7;
   localparam logic [3:0] S_FOUT   = 4'd8;
   localparam logic [3:0] S_ERR    = 4'd9;
   localparam logic [3:0] S_CNTRD  = 4'd10;

   // Memories: process table and page map, frame owner table.
   logic [15:0] ids_mem   [MAX_PROCS];
   logic [5:0]  pages_mem [MAX_PROCS];
   logic [FW-1:0] map_mem [MAX_PROCS*MAX_PAGES];
   logic [20:0] owner_mem [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] used_ff;

   logic [12:0] page_bytes_ff;
   logic [15:0] max_bytes_ff;
   logic [CW-1:0] frame_lim_ff;
   logic [CW-1:0] free_ff, free_in;
   logic [TW-1:0] total_ff, total_in;

   logic [3:0]  state_ff, state_in;
   req_type     req_ff;
   logic [SW-1:0] slot_ff, slot_in;
   logic [TW-1:0] scan_ff, scan_in;
   logic [NW-1:0] pg_ff, pg_in;
   logic [NW-1:0] npg_ff, npg_in;
   logic [2:0]  err_ff, err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [15:0] ids_rd_ff;
   logic [5:0]  pages_rd_ff;
   logic [FW-1:0] map_rd_ff;
   logic [20:0] owner_rd_ff;
   logic        used_rd_ff;

   logic [SW-1:0] tab_addr;
   logic        map_we, tab_we;
   logic [SW+PW-1:0] map_waddr, map_raddr;
   logic [FW-1:0] new_frame;
   logic        own_we;
   logic        pool_we;

   div_ctl_type div_ctl;
   logic        div_done;
   logic [16:0] div_pages;

   pfa_divider u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .done  (div_done),
      .pages (div_pages)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign new_frame = FW'(free_ff - CW'(1));
   assign pool_we   = csr_valid && csr_ready && (csr_index == REG_FRAME_COUNT);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      scan_in      = scan_ff;
      pg_in        = pg_ff;
      npg_in       = npg_ff;
      err_in       = err_ff;
      free_in      = free_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      tab_addr     = scan_ff[SW-1:0];
      tab_we       = 1'b0;
      map_we       = 1'b0;
      own_we       = 1'b0;
      map_waddr    = {slot_ff, pg_ff[PW-1:0]};
      map_raddr    = {slot_ff, pg_ff[PW-1:0]};
      div_ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            scan_in = '0;
            if (start) begin
               if (req_data.opcode inside {OP_CREATE, OP_MAP}) begin
                  state_in = S_SRCH;
               end else if (req_data.opcode == OP_FRAME) begin
                  state_in = S_FRD;
               end
            end
         end
         S_SRCH: begin
            // Issue one table read per step while entries remain.
            if (scan_ff >= total_ff) begin
               if (req_ff.opcode == OP_MAP) begin
                  err_in   = ST_NOT_FOUND;
                  state_in = S_ERR;
               end else if (req_ff.size_bytes > max_bytes_ff) begin
                  err_in   = ST_TOO_LARGE;
                  state_in = S_ERR;
               end else if (total_ff >= TW'(MAX_PROCS)) begin
                  err_in   = ST_FULL;
                  state_in = S_ERR;
               end else begin
                  div_ctl.start    = 1'b1;
                  div_ctl.dividend = req_ff.size_bytes;
                  div_ctl.divisor  = page_bytes_ff;
                  state_in = S_DIV;
               end
            end else begin
               state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (ids_rd_ff == req_ff.proc_id) begin
               slot_in = scan_ff[SW-1:0];
               if (req_ff.opcode == OP_MAP) begin
                  state_in = S_CNTRD;
               end else begin
                  err_in   = ST_DUPLICATE;
                  state_in = S_ERR;
               end
            end else begin
               scan_in  = scan_ff + TW'(1);
               state_in = S_SRCH;
            end
         end
         S_CNTRD: begin
            // Page count of the found slot was read along with its id.
            npg_in   = NW'(pages_rd_ff);
            pg_in    = '0;
            state_in = (pages_rd_ff == 6'd0) ? S_LOUT : S_LRD;
         end
         S_DIV: begin
            if (div_done) begin
               if (div_pages > 17'(MAX_PAGES)) begin
                  err_in   = ST_TOO_LARGE;
                  state_in = S_ERR;
               end else if (17'(free_ff) < div_pages) begin
                  err_in   = ST_NO_FRAMES;
                  state_in = S_ERR;
               end else begin
                  slot_in  = total_ff[SW-1:0];
                  npg_in   = NW'(div_pages);
                  pg_in    = '0;
                  tab_addr = total_ff[SW-1:0];
                  tab_we   = 1'b1;
                  state_in = S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            // Pop one frame per cycle and record both directions of the map; then count the new process.
            if (pg_ff == npg_ff) begin
               total_in = total_ff + TW'(1);
               pg_in    = '0;
               state_in = (npg_ff == '0) ? S_LOUT : S_LRD;
            end else begin
               map_we  = 1'b1;
               own_we  = 1'b1;
               free_in = free_ff - CW'(1);
               pg_in   = pg_ff + NW'(1);
            end
         end
         S_LRD: begin
            state_in = S_LOUT;
         end
         S_LOUT: begin
            rsp_valid_in = 1'b1;
            rsp_in.status = ST_OK;
            rsp_in.page_total = 6'(npg_ff);
            if (npg_ff == '0) begin
               rsp_in.last = 1'b1;
               state_in    = S_IDLE;
            end else begin
               rsp_in.page_index   = 5'(pg_ff);
               rsp_in.frame_number = 6'(map_rd_ff);
               rsp_in.entry_valid  = 1'b1;
               rsp_in.last         = (pg_ff + NW'(1) == npg_ff);
               pg_in    = pg_ff + NW'(1);
               state_in = rsp_in.last ? S_IDLE : S_LRD;
            end
         end
         S_FRD: begin
            state_in = S_FOUT;
         end
         S_FOUT: begin
            rsp_valid_in = 1'b1;
            rsp_in.last  = 1'b1;
            if (CW'(req_ff.frame_index) >= frame_lim_ff) begin
               rsp_in.status = ST_BAD_FRAME;
            end else begin
               rsp_in.status       = ST_OK;
               rsp_in.frame_number = req_ff.frame_index;
               if (used_rd_ff) begin
                  rsp_in.frame_in_use = 1'b1;
                  rsp_in.entry_valid  = 1'b1;
                  rsp_in.owner_id     = owner_rd_ff[20:5];
                  rsp_in.page_index   = owner_rd_ff[4:0];
               end
            end
            state_in = S_IDLE;
         end
         S_ERR: begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = err_ff;
            rsp_in.last   = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         page_bytes_ff <= 13'd32;
         max_bytes_ff  <= 16'd256;
         frame_lim_ff  <= (NUM_FRAMES < 32) ? CW'(NUM_FRAMES) : CW'(32);
         free_ff       <= (NUM_FRAMES < 32) ? CW'(NUM_FRAMES) : CW'(32);
         total_ff      <= '0;
         used_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         // A frame_count write rebuilds the pool; otherwise the sequencer owns it.
         if (pool_we) begin
            if (32'(csr_data[6:0]) > NUM_FRAMES) begin
               frame_lim_ff <= CW'(NUM_FRAMES);
               free_ff      <= CW'(NUM_FRAMES);
            end else begin
               frame_lim_ff <= CW'(csr_data[6:0]);
               free_ff      <= CW'(csr_data[6:0]);
            end
            total_ff <= '0;
            used_ff  <= '0;
         end else begin
            free_ff  <= free_in;
            total_ff <= total_in;
            if (own_we) begin
               used_ff[new_frame] <= 1'b1;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PAGE_BYTES:  page_bytes_ff <= csr_data[12:0];
               REG_MAX_BYTES:   max_bytes_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      scan_ff <= scan_in;
      pg_ff   <= pg_in;
      npg_ff  <= npg_in;
      err_ff  <= err_in;
      rsp_ff  <= rsp_in;
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // Process table memory.
   always_ff @(posedge clock) begin
      if (tab_we) begin
         ids_mem[tab_addr]   <= req_ff.proc_id;
         pages_mem[tab_addr] <= 6'(div_pages);
      end
      ids_rd_ff   <= ids_mem[tab_addr];
      pages_rd_ff <= pages_mem[tab_addr];
   end

   // Page map memory.
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= new_frame;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   // Frame owner memory.
   always_ff @(posedge clock) begin
      if (own_we) begin
         owner_mem[new_frame] <= {req_ff.proc_id, 5'(pg_ff)};
      end
      owner_rd_ff <= owner_mem[req_ff.frame_index[FW-1:0]];
      used_rd_ff  <= used_ff[req_ff.frame_index[FW-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
